>>> design/mnep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnep_pkg: shared constants and types for the midi note event parser
// byte class limits, note status nibbles and the result item record
// ----------------------------------------------------------------------------
package mnep_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned ChannelW = 4;

  // byte classes
  localparam logic [ByteW-1:0] VoiceMin  = 8'h80;
  localparam logic [ByteW-1:0] VoiceMax  = 8'hEF;
  localparam logic [ByteW-1:0] CommonMin = 8'hF0;
  localparam logic [ByteW-1:0] CommonMax = 8'hF7;
  localparam logic [ByteW-1:0] RealTimeMin = 8'hF8;

  // high nibble of the channel voice messages we decode
  localparam logic [3:0] NoteOffHi = 4'h8;
  localparam logic [3:0] NoteOnHi  = 4'h9;

  // running status value that means no status
  localparam logic [ByteW-1:0] NoStatus = 8'h00;

  typedef struct packed {
    logic             note_on;
    logic [NoteW-1:0] note_number;
    logic [VelW-1:0]  velocity;
  } note_event_t;

endpackage : mnep_pkg
`default_nettype wire

>>> design/mnep_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnep_decode: running status decoder
// classifies one byte, updates running status and pending note, builds event
// ----------------------------------------------------------------------------
module mnep_decode
  import mnep_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [ByteW-1:0]    byte_i,
  input  wire logic [ChannelW-1:0] channel_i,
  output logic                     evt_valid_o,
  output note_event_t              evt_o
);

  logic [ByteW-1:0] status_q, status_d;
  logic [NoteW-1:0] note_q, note_d;
  logic             have_q, have_d;

  logic is_voice, is_common, is_data;
  logic match_off, match_on;

  assign is_voice  = (byte_i >= VoiceMin) && (byte_i <= VoiceMax);
  assign is_common = (byte_i >= CommonMin) && (byte_i <= CommonMax);
  assign is_data   = ~byte_i[ByteW-1];

  assign match_off = (status_q == {NoteOffHi, channel_i});
  assign match_on  = (status_q == {NoteOnHi, channel_i});

  always_comb begin
    status_d    = status_q;
    note_d      = note_q;
    have_d      = have_q;
    evt_valid_o = 1'b0;
    evt_o.note_on     = match_on && (byte_i[VelW-1:0] != '0);
    evt_o.note_number = note_q;
    evt_o.velocity    = byte_i[VelW-1:0];
    if (fire_i) begin
      if (is_voice) begin
        status_d = byte_i;
        note_d   = '0;
        have_d   = 1'b0;
      end else if (is_common) begin
        status_d = NoStatus;
      end else if (is_data && (match_off || match_on)) begin
        if (!have_q) begin
          note_d = byte_i[NoteW-1:0];
          have_d = 1'b1;
        end else begin
          evt_valid_o = 1'b1;
          note_d      = '0;
          have_d      = 1'b0;
        end
      end
      // real-time bytes leave the state alone
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= NoStatus;
      note_q   <= '0;
      have_q   <= 1'b0;
    end else begin
      status_q <= status_d;
      note_q   <= note_d;
      have_q   <= have_d;
    end
  end

endmodule : mnep_decode
`default_nettype wire

>>> design/mnep_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mnep_out_reg: result register
// holds one event item until the consumer takes it
// ----------------------------------------------------------------------------
module mnep_out_reg
  import mnep_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_en_i,
  input  wire logic         load_valid_i,
  input  wire note_event_t  load_evt_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output note_event_t       out_evt_o
);

  logic        valid_q, valid_d;
  note_event_t evt_q, evt_d;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    evt_d   = evt_q;
    if (load_en_i && ready_o) begin
      valid_d = load_valid_i;
      evt_d   = load_evt_i;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign out_valid_o = valid_q;
  assign out_evt_o   = evt_q;

endmodule : mnep_out_reg
`default_nettype wire

>>> design/midi_note_event_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_note_event_parser: note on / note off decoder with running status
// path: the closing byte is held in the input byte register, decoded, and then
// captured in the result register, whose valid flag drives out_valid_o
// throughput: one byte per cycle, sustained while the output is not stalled
// the single decode stage sits between the input byte register and the
// result register; the result register lets a byte in while empty or unstalled
// reset: running status none, no pending note, channel 0, both registers empty
// ----------------------------------------------------------------------------
module midi_note_event_parser
  import mnep_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // channel register write
  input  wire logic                cfg_we_i,
  input  wire logic [ChannelW-1:0] cfg_wdata_i,
  // byte input
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ByteW-1:0]    midi_byte_i,
  // event output
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     note_on_o,
  output logic [NoteW-1:0]         note_number_o,
  output logic [VelW-1:0]          velocity_o
);

  // configured channel
  logic [ChannelW-1:0] channel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= '0;
    end else if (cfg_we_i) begin
      channel_q <= cfg_wdata_i;
    end
  end

  // input byte register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             stage_ready;   // result register can take this item's outcome
  logic             stage_fire;    // byte in the input register is decoded now
  logic             in_fire;

  assign stage_fire = in_valid_q && stage_ready;
  // the input register frees up whenever its byte is decoded in this cycle
  assign in_stall_o = in_valid_q && !stage_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    byte_d     = byte_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
      byte_d     = midi_byte_i;
    end else if (stage_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // decode and parser state; state advances only when the byte is consumed
  logic        evt_valid;
  note_event_t evt;

  mnep_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (stage_fire),
    .byte_i      (byte_q),
    .channel_i   (channel_q),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  // result register; bytes that make no event load an empty slot
  note_event_t out_evt;

  mnep_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (in_valid_q),
    .load_valid_i (evt_valid),
    .load_evt_i   (evt),
    .ready_o      (stage_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_evt_o    (out_evt)
  );

  assign note_on_o     = out_evt.note_on;
  assign note_number_o = out_evt.note_number;
  assign velocity_o    = out_evt.velocity;

endmodule : midi_note_event_parser
`default_nettype wire
